// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types, field widths, command codes and reset values.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Item kinds, carried on the slave-side tuser.
  localparam logic [1:0] MODE_CPU_WRITE = 2'd0;
  localparam logic [1:0] MODE_PPU_FETCH = 2'd1;
  localparam logic [1:0] MODE_CPU_TICK  = 2'd2;
  localparam logic [1:0] MODE_CPU_READ  = 2'd3;

  // Register window of a CPU write, CPU address bits 14:13.
  localparam logic [1:0] WIN_BANK   = 2'd0;
  localparam logic [1:0] WIN_MIRROR = 2'd1;
  localparam logic [1:0] WIN_IRQ    = 2'd2;
  localparam logic [1:0] WIN_ENABLE = 2'd3;

  // Bank register select, low four bits of the command register.
  localparam logic [3:0] SEL_CHR0 = 4'd0;
  localparam logic [3:0] SEL_CHR1 = 4'd1;
  localparam logic [3:0] SEL_CHR2 = 4'd2;
  localparam logic [3:0] SEL_CHR3 = 4'd3;
  localparam logic [3:0] SEL_CHR4 = 4'd4;
  localparam logic [3:0] SEL_CHR5 = 4'd5;
  localparam logic [3:0] SEL_PRG0 = 4'd6;
  localparam logic [3:0] SEL_PRG1 = 4'd7;
  localparam logic [3:0] SEL_CHR6 = 4'd8;
  localparam logic [3:0] SEL_CHR7 = 4'd9;
  localparam logic [3:0] SEL_PRG2 = 4'd15;

  // Command register control bits.
  localparam int unsigned CMD_CHR_1K  = 5;
  localparam int unsigned CMD_PRG_SWAP = 6;
  localparam int unsigned CMD_CHR_INV = 7;

  // Configuration register indexes.
  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  localparam logic [7:0] PRG_MASK_RESET = 8'h0F;
  localparam logic [7:0] CHR_MASK_RESET = 8'hFF;
  localparam logic [7:0] PRG2_RESET     = 8'hFE;
  localparam logic [7:0] FIXED_BANK     = 8'hFF;

  // Minimum ppu_time distance between two counted rises of A12.
  localparam logic [31:0] EDGE_GAP = 32'd16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [13:0] ppu_address;
    logic [31:0] ppu_time;
  } cbm_item_t;

  // Banking registers seen by the translator.
  typedef struct packed {
    logic [7:0]      command;
    logic [7:0][7:0] chr;
    logic [2:0][7:0] prg;
  } cbm_banks_t;

  // Interrupt and mirroring status.
  typedef struct packed {
    logic       irq_pending;
    logic       irq_enable;
    logic [8:0] irq_count;
    logic       mirror;
  } cbm_status_t;

endpackage

// ===== rtl/cbm_state.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper register file
// Decodes CPU writes and runs the A12 and CPU-cycle interrupt counter.
// ----------------------------------------------------------------------------
module cbm_state import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  cbm_item_t   item,
  output cbm_banks_t  banks,
  output cbm_status_t status,
  output cbm_status_t status_next
);

  logic [7:0]      command;
  logic [7:0][7:0] chr;
  logic [2:0][7:0] prg;
  logic            mirror;
  logic [7:0]      irq_reload;
  logic [8:0]      irq_count;
  logic            irq_cpu_mode;
  logic            irq_enable;
  logic            irq_pending;
  logic [1:0]      prescale;
  logic            last_a12;
  logic [31:0]     last_edge_time;

  logic [7:0]      command_next;
  logic [7:0][7:0] chr_next;
  logic [2:0][7:0] prg_next;
  logic            mirror_next;
  logic [7:0]      irq_reload_next;
  logic [8:0]      irq_count_next;
  logic            irq_cpu_mode_next;
  logic            irq_enable_next;
  logic            irq_pending_next;
  logic [1:0]      prescale_next;
  logic            last_a12_next;
  logic [31:0]     last_edge_time_next;

  logic            wr;
  logic            odd;
  logic            a12;
  logic            tick;
  logic [31:0]     elapsed;

  // Next state for one item; modes are exclusive, so the write decode and
  // the counter clock never meet on the same item.
  always_comb begin
    command_next        = command;
    chr_next            = chr;
    prg_next            = prg;
    mirror_next         = mirror;
    irq_reload_next     = irq_reload;
    irq_count_next      = irq_count;
    irq_cpu_mode_next   = irq_cpu_mode;
    irq_enable_next     = irq_enable;
    irq_pending_next    = irq_pending;
    prescale_next       = prescale;
    last_a12_next       = last_a12;
    last_edge_time_next = last_edge_time;
    tick                = 1'b0;

    wr      = (item.mode == MODE_CPU_WRITE) && item.cpu_address[15];
    odd     = item.cpu_address[0];
    a12     = item.ppu_address[12];
    elapsed = item.ppu_time - last_edge_time;

    // CPU register writes.
    if (wr) begin
      case (item.cpu_address[14:13])
        WIN_BANK: begin
          if (!odd) begin
            command_next = item.write_data;
          end else begin
            case (command[3:0])
              SEL_CHR0, SEL_CHR1, SEL_CHR2,
              SEL_CHR3, SEL_CHR4, SEL_CHR5: chr_next[command[2:0]] = item.write_data;
              SEL_PRG0: prg_next[0] = item.write_data;
              SEL_PRG1: prg_next[1] = item.write_data;
              SEL_CHR6: chr_next[6] = item.write_data;
              SEL_CHR7: chr_next[7] = item.write_data;
              SEL_PRG2: prg_next[2] = item.write_data;
              default: ;
            endcase
          end
        end
        WIN_MIRROR: begin
          if (!odd) begin
            mirror_next = item.write_data[0];
          end
        end
        WIN_IRQ: begin
          if (!odd) begin
            irq_reload_next = item.write_data;
          end else begin
            irq_count_next    = '0;
            irq_cpu_mode_next = item.write_data[0];
          end
        end
        default: begin
          if (!odd) begin
            irq_enable_next  = 1'b0;
            irq_pending_next = 1'b0;
          end else begin
            irq_enable_next = 1'b1;
          end
        end
      endcase
    end

    // Filtered rises of A12 step the counter in PPU counting mode.
    if (item.mode == MODE_PPU_FETCH && !irq_cpu_mode) begin
      if (a12 && !last_a12) begin
        tick                = (elapsed >= EDGE_GAP);
        last_edge_time_next = item.ppu_time;
      end
      last_a12_next = a12;
    end

    // Every fourth CPU cycle clocks the counter in CPU counting mode.
    if (item.mode == MODE_CPU_TICK && irq_cpu_mode) begin
      prescale_next = prescale + 2'd1;
      tick          = (prescale_next == 2'd0);
    end

    // Counter clock: reload on zero, else count down; flag on reaching zero while enabled.
    if (tick) begin
      if (irq_count == 9'd0) begin
        irq_count_next = {1'b0, irq_reload} + 9'd1;
      end else begin
        irq_count_next = irq_count - 9'd1;
      end
      if (irq_enable && irq_count_next == 9'd0) begin
        irq_pending_next = 1'b1;
      end
    end
  end

  // State registers move only when an item passes to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      command        <= '0;
      for (int i = 0; i < 8; i++) begin
        chr[i] <= 8'(i);
      end
      prg[0]         <= 8'h00;
      prg[1]         <= 8'h01;
      prg[2]         <= PRG2_RESET;
      mirror         <= 1'b0;
      irq_reload     <= '0;
      irq_count      <= '0;
      irq_cpu_mode   <= 1'b0;
      irq_enable     <= 1'b0;
      irq_pending    <= 1'b0;
      prescale       <= '0;
      last_a12       <= 1'b0;
      last_edge_time <= '0;
    end else if (advance) begin
      command        <= command_next;
      chr            <= chr_next;
      prg            <= prg_next;
      mirror         <= mirror_next;
      irq_reload     <= irq_reload_next;
      irq_count      <= irq_count_next;
      irq_cpu_mode   <= irq_cpu_mode_next;
      irq_enable     <= irq_enable_next;
      irq_pending    <= irq_pending_next;
      prescale       <= prescale_next;
      last_a12       <= last_a12_next;
      last_edge_time <= last_edge_time_next;
    end
  end

  assign banks.command = command;
  assign banks.chr     = chr;
  assign banks.prg     = prg;

  assign status.irq_pending = irq_pending;
  assign status.irq_enable  = irq_enable;
  assign status.irq_count   = irq_count;
  assign status.mirror      = mirror;

  assign status_next.irq_pending = irq_pending_next;
  assign status_next.irq_enable  = irq_enable_next;
  assign status_next.irq_count   = irq_count_next;
  assign status_next.mirror      = mirror_next;

endmodule

// ===== rtl/cbm_xlate.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper address translator
// Maps CPU addresses to 8 KB PRG banks and PPU addresses to 1 KB CHR banks.
// ----------------------------------------------------------------------------
module cbm_xlate import cbm_pkg::*; (
  input  cbm_item_t  item,
  input  cbm_banks_t banks,
  input  logic [7:0] prg_mask,
  input  logic [7:0] chr_mask,
  output logic [7:0] bank,
  output logic       bank_valid
);

  logic [1:0] prg_slot;
  logic [1:0] prg_idx;
  logic [7:0] prg_raw;
  logic [2:0] chr_slot;
  logic [2:0] chr_idx;
  logic [7:0] chr_raw;

  // PRG: the last window is fixed; the swap bit rotates the first three.
  always_comb begin
    prg_slot = item.cpu_address[14:13];
    if (banks.command[CMD_PRG_SWAP]) begin
      prg_idx = (prg_slot == 2'd0) ? 2'd2 : prg_slot - 2'd1;
    end else begin
      prg_idx = prg_slot;
    end
    prg_raw = (prg_slot == 2'd3) ? FIXED_BANK : banks.prg[prg_idx];
  end

  // CHR: the invert bit swaps halves; the low half is either four 1 KB
  // windows or two 2 KB windows with the low bit taken from the address.
  always_comb begin
    chr_slot = item.ppu_address[12:10] ^ {banks.command[CMD_CHR_INV], 2'b00};
    if (chr_slot[2]) begin
      chr_idx = chr_slot - 3'd2;
    end else if (banks.command[CMD_CHR_1K]) begin
      case (chr_slot[1:0])
        2'd0:    chr_idx = 3'd0;
        2'd1:    chr_idx = 3'd6;
        2'd2:    chr_idx = 3'd1;
        default: chr_idx = 3'd7;
      endcase
    end else begin
      chr_idx = {2'b00, chr_slot[1]};
    end
    chr_raw = banks.chr[chr_idx];
    if (!chr_slot[2] && !banks.command[CMD_CHR_1K]) begin
      chr_raw = {chr_raw[7:1], chr_slot[0]};
    end
  end

  // Pick the translation that applies to this item kind.
  always_comb begin
    bank       = '0;
    bank_valid = 1'b0;
    if (item.mode == MODE_CPU_READ && item.cpu_address[15]) begin
      bank       = prg_raw & prg_mask;
      bank_valid = 1'b1;
    end else if (item.mode == MODE_PPU_FETCH && !item.ppu_address[13]) begin
      bank       = chr_raw & chr_mask;
      bank_valid = 1'b1;
    end
  end

endmodule

// ===== rtl/cartridge_bank_mapper_with_irq.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper with interrupt counter
// Bank register file, A12 / CPU-cycle interrupt counter and bank translator.
// ----------------------------------------------------------------------------
// Path: an input beat is taken into the input register, then passes to the
// result register once that is empty or being read, and is offered from there.
// Throughput: one item per cycle while m_tready is high; the state update
// and translation for an item fit in one logic stage between the registers.
// Reset (rst, synchronous): banks, counter and masks return to their reset
// values and both registers empty; the configuration port is always ready.
module cartridge_bank_mapper_with_irq import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input item stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // cpu_address[15:0], write_data[23:16],
                                 // ppu_address[37:24], ppu_time[69:38], zero
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // irq_line[0], mirroring[1], bank[9:2], zero
  output logic        m_tuser,   // bank_valid[0]
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  cbm_item_t   item;
  logic        item_valid;
  logic        advance;
  logic [7:0]  prg_mask;
  logic [7:0]  chr_mask;
  cbm_banks_t  banks;
  cbm_status_t status;
  cbm_status_t status_next;
  logic [7:0]  bank;
  logic        bank_valid;

  assign advance   = item_valid && (!m_tvalid || m_tready);
  assign s_tready  = !item_valid || advance;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.mode        <= s_tuser;
      item.cpu_address <= s_tdata[15:0];
      item.write_data  <= s_tdata[23:16];
      item.ppu_address <= s_tdata[37:24];
      item.ppu_time    <= s_tdata[69:38];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_mask <= PRG_MASK_RESET;
      chr_mask <= CHR_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRG_MASK: prg_mask <= cfg_data;
        CFG_CHR_MASK: chr_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  cbm_state u_state (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item),
    .banks       (banks),
    .status      (status),
    .status_next (status_next)
  );

  cbm_xlate u_xlate (
    .item       (item),
    .banks      (banks),
    .prg_mask   (prg_mask),
    .chr_mask   (chr_mask),
    .bank       (bank),
    .bank_valid (bank_valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b0, bank, status_next.mirror, status_next.irq_pending};
      m_tuser <= bank_valid;
    end
  end

  // A bank number is reported only with a valid translation.
  a_bank_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[9:2] == 8'd0)
    else $error("bank field nonzero without a translation");

  // The interrupt can only become pending while it is enabled.
  a_irq_enabled: assert property (@(posedge clk) disable iff (rst)
    $rose(status.irq_pending) |-> $past(status.irq_enable))
    else $error("interrupt raised while disabled");

  // The counter never exceeds the largest reload value plus one.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.irq_count <= 9'd256)
    else $error("interrupt counter out of range");

  // A new result appears only from a held input item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(item_valid))
    else $error("result without an input item");

endmodule

// ===== verif/bank_mapper_checker.sv =====
// ----------------------------------------------------------------------------
// Bank mapper checker
// Watches the item, result and configuration channels of the bank mapper,
// keeps its own copy of the banking and interrupt state, works out the report
// for every accepted item and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module bank_mapper_checker import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // cpu_address[15:0], write_data[23:16],
                                 // ppu_address[37:24], ppu_time[69:38], zero
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // irq_line[0], mirroring[1], bank[9:2], zero
  input  logic        m_tuser,   // bank_valid[0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic       irq_line;
    logic       mirroring;
    logic [7:0] bank;
    logic       bank_valid;
  } map_report_t;

  // Shadow copy of the mapper state.
  logic [7:0]  prg_mask;
  logic [7:0]  chr_mask;
  logic [7:0]  command;
  logic [7:0]  chr_bank [8];
  logic [7:0]  prg_bank [3];
  logic        mirror;
  logic [7:0]  reload;
  logic [8:0]  count;
  logic        cpu_clocked;
  logic        irq_en;
  logic        irq_pend;
  logic [1:0]  prescale;
  logic        a12_prev;
  logic [31:0] edge_stamp;

  map_report_t awaited_reports [$];
  int          mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // One clock of the interrupt counter.
  function automatic void step_irq_counter();
    if (count == 9'd0) count = {1'b0, reload} + 9'd1;
    else count = count - 9'd1;
    if (irq_en && count == 9'd0) irq_pend = 1'b1;
  endfunction

  // Applies one item to the shadow state and returns the report it causes.
  function automatic map_report_t translate_and_count(input cbm_item_t it);
    map_report_t r;
    logic [2:0]  slot;
    logic [1:0]  window;
    logic [7:0]  b;
    logic        odd;
    r      = '0;
    odd    = it.cpu_address[0];
    window = it.cpu_address[14:13];
    case (it.mode)
      MODE_CPU_WRITE: begin
        if (it.cpu_address[15]) begin
          case (window)
            WIN_BANK: begin
              if (!odd) begin
                command = it.write_data;
              end else begin
                case (command[3:0])
                  SEL_CHR0, SEL_CHR1, SEL_CHR2, SEL_CHR3, SEL_CHR4, SEL_CHR5:
                    chr_bank[command[2:0]] = it.write_data;
                  SEL_PRG0: prg_bank[0] = it.write_data;
                  SEL_PRG1: prg_bank[1] = it.write_data;
                  SEL_CHR6: chr_bank[6] = it.write_data;
                  SEL_CHR7: chr_bank[7] = it.write_data;
                  SEL_PRG2: prg_bank[2] = it.write_data;
                  default: ;
                endcase
              end
            end
            WIN_MIRROR: begin
              if (!odd) mirror = it.write_data[0];
            end
            WIN_IRQ: begin
              if (!odd) begin
                reload = it.write_data;
              end else begin
                count       = 9'd0;
                cpu_clocked = it.write_data[0];
              end
            end
            default: begin
              if (!odd) begin
                irq_en   = 1'b0;
                irq_pend = 1'b0;
              end else begin
                irq_en = 1'b1;
              end
            end
          endcase
        end
      end
      MODE_PPU_FETCH: begin
        // Rises of A12 only step the counter while it follows the video bus.
        if (!cpu_clocked) begin
          if (it.ppu_address[12] && !a12_prev) begin
            if (it.ppu_time - edge_stamp >= EDGE_GAP) step_irq_counter();
            edge_stamp = it.ppu_time;
          end
          a12_prev = it.ppu_address[12];
        end
        // Pattern table addresses map to 1 KB CHR banks.
        if (!it.ppu_address[13]) begin
          slot = it.ppu_address[12:10];
          if (command[CMD_CHR_INV]) slot[2] = ~slot[2];
          if (slot[2]) begin
            b = chr_bank[slot - 3'd2];
          end else if (command[CMD_CHR_1K]) begin
            case (slot[1:0])
              2'd0: b = chr_bank[0];
              2'd1: b = chr_bank[6];
              2'd2: b = chr_bank[1];
              default: b = chr_bank[7];
            endcase
          end else begin
            b = {chr_bank[slot[1]][7:1], slot[0]};
          end
          r.bank       = b & chr_mask;
          r.bank_valid = 1'b1;
        end
      end
      MODE_CPU_TICK: begin
        if (cpu_clocked) begin
          prescale = prescale + 2'd1;
          if (prescale == 2'd0) step_irq_counter();
        end
      end
      default: begin
        // The last 8 KB window is fixed; the swap bit rotates the first three.
        if (it.cpu_address[15]) begin
          if (window == 2'd3) b = FIXED_BANK;
          else if (command[CMD_PRG_SWAP])
            b = prg_bank[window == 2'd0 ? 2 : window - 1];
          else b = prg_bank[window];
          r.bank       = b & prg_mask;
          r.bank_valid = 1'b1;
        end
      end
    endcase
    r.irq_line  = irq_pend;
    r.mirroring = mirror;
    return r;
  endfunction

  // Follow the channels beat by beat.
  always @(posedge clk) begin
    cbm_item_t   it;
    map_report_t got;
    map_report_t want;
    if (rst) begin
      prg_mask    = PRG_MASK_RESET;
      chr_mask    = CHR_MASK_RESET;
      command     = 8'd0;
      for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
      prg_bank[0] = 8'd0;
      prg_bank[1] = 8'd1;
      prg_bank[2] = PRG2_RESET;
      mirror      = 1'b0;
      reload      = 8'd0;
      count       = 9'd0;
      cpu_clocked = 1'b0;
      irq_en      = 1'b0;
      irq_pend    = 1'b0;
      prescale    = 2'd0;
      a12_prev    = 1'b0;
      edge_stamp  = 32'd0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_MASK) prg_mask = cfg_data;
        else chr_mask = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        it.mode        = s_tuser;
        it.cpu_address = s_tdata[15:0];
        it.write_data  = s_tdata[23:16];
        it.ppu_address = s_tdata[37:24];
        it.ppu_time    = s_tdata[69:38];
        awaited_reports.push_back(translate_and_count(it));
      end
      if (m_tvalid && m_tready) begin
        got.irq_line   = m_tdata[0];
        got.mirroring  = m_tdata[1];
        got.bank       = m_tdata[9:2];
        got.bank_valid = m_tuser;
        if (awaited_reports.size() == 0) begin
          if (mismatches < 10)
            $display({"%0t: result beat with nothing awaited: ",
                      "irq %0b mirror %0b bank %02h valid %0b"},
                     $realtime, got.irq_line, got.mirroring, got.bank, got.bank_valid);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (got.irq_line != want.irq_line || got.mirroring != want.mirroring ||
              got.bank != want.bank || got.bank_valid != want.bank_valid) begin
            if (mismatches < 10)
              $display({"%0t: mismatch: irq %0b/%0b mirror %0b/%0b ",
                        "bank %02h/%02h valid %0b/%0b (exp/got)"},
                       $realtime, want.irq_line, got.irq_line,
                       want.mirroring, got.mirroring,
                       want.bank, got.bank, want.bank_valid, got.bank_valid);
            mismatches++;
          end
        end
      end
    end
    outstanding <= awaited_reports.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== verif/cartridge_bank_mapper_with_irq_test.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives directed and random bus items through the mapper under several
// idling patterns and mask settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_test;
  import cbm_pkg::*;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 285;
  localparam int HOLD_CYCLES = 64;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = MODE_CPU_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PRG_MASK;
  logic [7:0]  cfg_data = '0;

  int          fail_count;
  int          outstanding;

  // Pacing of both sides.
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_arm = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  logic [31:0] ppu_clock = 32'd0;

  cartridge_bank_mapper_with_irq dut (.*);

  bank_mapper_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL cartridge_bank_mapper_with_irq");
    $finish;
  end

  // Result side: random stalls plus one long hold-off when armed.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_taken) begin
      m_tready   <= 1'b0;
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
    end else begin
      m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic cbm_item_t make_item(logic [1:0] mode, logic [15:0] caddr,
                                          logic [7:0] data, logic [13:0] paddr,
                                          logic [31:0] ptime);
    cbm_item_t it;
    it.mode        = mode;
    it.cpu_address = caddr;
    it.write_data  = data;
    it.ppu_address = paddr;
    it.ppu_time    = ptime;
    return it;
  endfunction

  // Random item, weighted toward mapper writes that set up banks and the
  // counter, and PPU fetches on a slowly advancing cycle stamp.
  function automatic cbm_item_t next_random_item();
    cbm_item_t it;
    int        pick;
    int        w;
    pick           = $urandom_range(99);
    it.cpu_address = 16'($urandom);
    it.write_data  = 8'($urandom);
    it.ppu_address = 14'($urandom);
    it.ppu_time    = $urandom;
    if (pick < 25) begin
      it.mode = MODE_CPU_WRITE;
      it.cpu_address[15] = 1'b1;
      w = $urandom_range(99);
      if (w < 40) it.cpu_address[14:13] = WIN_BANK;
      else if (w < 50) it.cpu_address[14:13] = WIN_MIRROR;
      else if (w < 75) it.cpu_address[14:13] = WIN_IRQ;
      else it.cpu_address[14:13] = WIN_ENABLE;
      // Short reload values let the counter reach zero often.
      if (it.cpu_address[14:13] == WIN_IRQ && !it.cpu_address[0] && $urandom_range(3) != 0)
        it.write_data = 8'($urandom_range(7));
    end else if (pick < 30) begin
      it.mode = MODE_CPU_WRITE;
      it.cpu_address[15] = 1'b0;
    end else if (pick < 60) begin
      it.mode = MODE_PPU_FETCH;
      if ($urandom_range(39) == 0) ppu_clock = $urandom;
      else ppu_clock = ppu_clock + 32'($urandom_range(30));
      it.ppu_time = ppu_clock;
    end else if (pick < 75) begin
      it.mode = MODE_CPU_TICK;
    end else begin
      it.mode = MODE_CPU_READ;
    end
    return it;
  endfunction

  task automatic send_item(input cbm_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {2'b00, it.ppu_time, it.ppu_address, it.write_data, it.cpu_address};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait until every awaited result has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(input logic index, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int idle_by_phase [PHASES];
    int stall_by_phase [PHASES];
    logic [7:0] prg_by_phase [PHASES];
    logic [7:0] chr_by_phase [PHASES];
    idle_by_phase  = '{0, 78, 0, 26, 0};
    stall_by_phase = '{0, 0, 78, 26, 0};
    prg_by_phase   = '{8'hFF, 8'h01, 8'h3F, 8'($urandom_range(255, 1)), PRG_MASK_RESET};
    chr_by_phase   = '{8'hFF, 8'h00, 8'h7F, 8'($urandom_range(255)), CHR_MASK_RESET};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset mapping, the fixed bank and a read below the cartridge space.
    send_item(make_item(MODE_CPU_READ, 16'h8000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_READ, 16'hA000, 8'hFF, 14'h3FFF, 32'hFFFFFFFF));
    send_item(make_item(MODE_CPU_READ, 16'hC000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_READ, 16'hFFFF, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_READ, 16'h7FFF, 8'h00, 14'h0000, 32'd0));
    // CHR lookups, an early A12 edge, and fetches above the pattern tables.
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h1FFF, 32'd0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h2000, 32'd4));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h3FFF, 32'd40));
    // Ignored low write, every command control bit, an unused select.
    send_item(make_item(MODE_CPU_WRITE, 16'h7FFF, 8'hFF, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_WRITE, 16'h8000, 8'hEA, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_WRITE, 16'h8001, 8'h55, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_READ, 16'h8000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h0400, 32'd41));
    // Mirroring: the odd address is ignored.
    send_item(make_item(MODE_CPU_WRITE, 16'hA001, 8'h01, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_WRITE, 16'hA000, 8'hFF, 14'h0000, 32'd0));
    // Counter on rises of A12, including a stamp that wraps around.
    send_item(make_item(MODE_CPU_WRITE, 16'hC000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_CPU_WRITE, 16'hE001, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h1000, 32'hFFFFFFF0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h0000, 32'hFFFFFFF8));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h1000, 32'h00000004));
    send_item(make_item(MODE_CPU_WRITE, 16'hE000, 8'h00, 14'h0000, 32'd0));
    // CPU-cycle counting: every fourth tick steps the counter, PPU fetches ignored.
    send_item(make_item(MODE_CPU_WRITE, 16'hC001, 8'hFF, 14'h0000, 32'd0));
    repeat (4) send_item(make_item(MODE_CPU_TICK, 16'h0000, 8'h00, 14'h0000, 32'd0));
    send_item(make_item(MODE_PPU_FETCH, 16'h0000, 8'h00, 14'h1000, 32'd500));
    drain();

    // Random phases, each with its own masks and pacing.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_mask(CFG_PRG_MASK, prg_by_phase[phase]);
      write_mask(CFG_CHR_MASK, chr_by_phase[phase]);
      send_idle_pct = idle_by_phase[phase];
      stall_pct    <= stall_by_phase[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 40) hold_arm <= 1'b1;
        send_item(next_random_item());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS cartridge_bank_mapper_with_irq");
    end else begin
      $display("FAIL cartridge_bank_mapper_with_irq");
    end
    $finish;
  end

endmodule
